// File: rtl/jfcp_pkg.sv
`default_nettype none

package jfcp_pkg;

   // frame store geometry
   localparam int FRAME_BYTES = 262144;
   localparam int FB_AW       = $clog2(FRAME_BYTES);
   localparam int CNT_W       = FB_AW + 1;
   localparam int NUM_W       = CNT_W + 1;

   // packet geometry
   localparam int HDR_LEN = 38;
   localparam int PAY_W   = 13;
   localparam int POS_W   = 13;
   localparam int PAY_MAX = 7200;

   // header constants
   localparam logic [31:0] HDR_TAG = 32'h4553_4A50;
   localparam logic [7:0]  MRK_FF  = 8'hFF;
   localparam logic [7:0]  MRK_SOI = 8'hD8;
   localparam logic [7:0]  MRK_EOI = 8'hD9;

   // result status codes
   typedef enum logic [1:0] {
      ST_PACKET  = 2'd0,
      ST_BAD     = 2'd1,
      ST_TOO_BIG = 2'd2
   } status_type;

   // control register indexes
   typedef enum logic [1:0] {
      CSR_DEVICE_ID = 2'd0,
      CSR_VERSION   = 2'd1,
      CSR_PAYLOAD   = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

// File: rtl/jfcp_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module jfcp_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [jfcp_pkg::NUM_W-1:0]    num,
   input  wire logic [jfcp_pkg::PAY_W-1:0]    den,
   output      logic                          done,
   output      logic [jfcp_pkg::NUM_W-1:0]    quot
);

   localparam int CW = $clog2(jfcp_pkg::NUM_W + 1);

   logic [jfcp_pkg::NUM_W-1:0] q_ff, q_in;
   logic [jfcp_pkg::PAY_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic                       run_ff, run_in, done_ff, done_in;
   logic [jfcp_pkg::PAY_W:0]   trial;

   // one shift and trial subtract a step
   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, q_ff[jfcp_pkg::NUM_W-1]};
      if (start) begin
         q_in   = num;
         rem_in = '0;
         den_in = den;
         cnt_in = CW'(jfcp_pkg::NUM_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = jfcp_pkg::PAY_W'(trial - {1'b0, den_ff});
            q_in   = {q_ff[jfcp_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[jfcp_pkg::PAY_W-1:0];
            q_in   = {q_ff[jfcp_pkg::NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

`default_nettype wire

// File: rtl/jpeg_frame_chunk_packetizer.sv
`default_nettype none

// Frame bytes are loaded one per cycle while busy is low into a
// single-port-write frame store while a CRC-32 and a byte count run along.
// Advance words are also taken one per cycle while busy is low; each gives
// its packet byte on the rsp_ ports in the next cycle, as the frame store
// read is registered. The receiver cannot stall, so the strobe must be taken
// when it appears. After the last byte of a frame, busy stays high while the
// chunk count is worked out by a bit-serial divider (one quotient bit a
// cycle); a drop result, if any, appears as that ends. Loads taken while a
// frame is being emitted are discarded.
module jpeg_frame_chunk_packetizer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   input  wire logic [31:0] req_frame_seq,
   input  wire logic [31:0] req_stamp_ms,
   input  wire logic [15:0] req_frame_width,
   input  wire logic [15:0] req_frame_height,
   output      logic        rsp_valid,
   output      logic [7:0]  rsp_out_byte,
   output      logic        rsp_end_of_packet,
   output      logic        rsp_end_of_frame,
   output      logic [1:0]  rsp_status,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int CW = jfcp_pkg::CNT_W;
   localparam int AW = jfcp_pkg::FB_AW;
   localparam int PW = jfcp_pkg::PAY_W;
   localparam int SW = jfcp_pkg::POS_W;

   typedef enum logic [0:0] {S_IDLE, S_DIV} state_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ 32'hEDB8_8320) : (r >> 1);
      end
      return r;
   endfunction

   // frame store
   logic [7:0]    mem [jfcp_pkg::FRAME_BYTES];
   logic [7:0]    mem_q_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;

   // control registers
   logic [31:0]   dev_ff, dev_in;
   logic [1:0]    ver_ff, ver_in;
   logic [PW-1:0] pay_cfg_ff, pay_cfg_in;

   // load state
   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0]   crc_ff, crc_in;
   logic [15:0]   first_ff, first_in, last_ff, last_in;

   // latched frame
   logic [31:0]   seq_ff, seq_in, stamp_ff, stamp_in, ldev_ff, ldev_in, lcrc_ff, lcrc_in;
   logic [15:0]   w_ff, w_in, h_ff, h_in;
   logic [1:0]    lver_ff, lver_in;
   logic [PW-1:0] lpay_ff, lpay_in;
   logic [CW-1:0] llen_ff, llen_in;
   logic          big_ff, big_in, bad_ff, bad_in;

   // emission state
   logic          emit_ff, emit_in;
   logic [15:0]   ctot_ff, ctot_in, cnum_ff, cnum_in;
   logic [SW-1:0] pos_ff, pos_in;
   logic [CW-1:0] coff_ff, coff_in;
   logic [AW-1:0] rptr_ff, rptr_in;

   // result register
   logic          v_ff, v_in, usem_ff, usem_in, eop_ff, eop_in, eof_ff, eof_in;
   logic [7:0]    byte_ff, byte_in;
   logic [1:0]    st_ff, st_in;

   // divider
   logic                       div_start, div_done;
   logic [jfcp_pkg::NUM_W-1:0] dnum, dquot;

   logic          acc, ld, adv;
   logic [CW-1:0] cnt_n, rest;
   logic [PW-1:0] pay_c;
   logic [15:0]   first_n, last_n, plen;
   logic [31:0]   crc_n;
   logic [303:0]  hdr;
   logic [5:0]    hsel;
   logic          eop, eof;

   assign acc = start && !busy;
   assign ld  = acc && !req_kind && !emit_ff;
   assign adv = acc && req_kind && emit_ff;

   // next load values
   always_comb begin
      cnt_n   = (cnt_ff <= CW'(jfcp_pkg::FRAME_BYTES)) ? cnt_ff + CW'(1) : cnt_ff;
      first_n = first_ff;
      if (cnt_ff == CW'(0)) first_n = {req_data_byte, 8'd0};
      else if (cnt_ff == CW'(1)) first_n = {first_ff[15:8], req_data_byte};
      last_n  = {last_ff[7:0], req_data_byte};
      crc_n   = crc_byte(crc_ff, req_data_byte);
      if (pay_cfg_ff == '0) pay_c = PW'(1);
      else if (pay_cfg_ff > PW'(jfcp_pkg::PAY_MAX)) pay_c = PW'(jfcp_pkg::PAY_MAX);
      else pay_c = pay_cfg_ff;
   end

   assign mem_we    = ld && (cnt_ff < CW'(jfcp_pkg::FRAME_BYTES));
   assign mem_waddr = cnt_ff[AW-1:0];
   assign dnum      = jfcp_pkg::NUM_W'(cnt_n) + jfcp_pkg::NUM_W'(pay_c)
                      - jfcp_pkg::NUM_W'(1);
   assign div_start = ld && req_last_byte;

   jfcp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (dnum),
      .den   (lpay_in),
      .done  (div_done),
      .quot  (dquot)
   );

   // packet position decode
   always_comb begin
      rest = llen_ff - coff_ff;
      plen = (rest > CW'(lpay_ff)) ? 16'(lpay_ff) : 16'(rest);
      eop  = ({1'b0, pos_ff} + (SW+1)'(1)) >= ((SW+1)'(jfcp_pkg::HDR_LEN) + (SW+1)'(plen));
      eof  = eop && (({1'b0, cnum_ff} + 17'd1) >= {1'b0, ctot_ff});
      hdr  = {jfcp_pkg::HDR_TAG, 6'd0, lver_ff, 8'd0, 16'(jfcp_pkg::HDR_LEN), ldev_ff,
              seq_ff, stamp_ff, 32'(llen_ff), lcrc_ff, cnum_ff, ctot_ff, plen, w_ff, h_ff};
      hsel = 6'(jfcp_pkg::HDR_LEN - 1) - pos_ff[5:0];
   end

   // next state
   always_comb begin
      dev_in = dev_ff; ver_in = ver_ff; pay_cfg_in = pay_cfg_ff;
      state_in = state_ff; cnt_in = cnt_ff; crc_in = crc_ff;
      first_in = first_ff; last_in = last_ff;
      seq_in = seq_ff; stamp_in = stamp_ff; ldev_in = ldev_ff; lcrc_in = lcrc_ff;
      w_in = w_ff; h_in = h_ff; lver_in = lver_ff; lpay_in = lpay_ff; llen_in = llen_ff;
      big_in = big_ff; bad_in = bad_ff;
      emit_in = emit_ff; ctot_in = ctot_ff; cnum_in = cnum_ff; pos_in = pos_ff;
      coff_in = coff_ff; rptr_in = rptr_ff;
      v_in = 1'b0; usem_in = 1'b0; eop_in = 1'b0; eof_in = 1'b0;
      byte_in = 8'd0; st_in = jfcp_pkg::ST_PACKET;

      // register writes
      if (csr_we) begin
         case (jfcp_pkg::csr_index_type'(csr_index))
            jfcp_pkg::CSR_DEVICE_ID: dev_in = csr_data;
            jfcp_pkg::CSR_VERSION:   ver_in = csr_data[1:0];
            jfcp_pkg::CSR_PAYLOAD:   pay_cfg_in = csr_data[PW-1:0];
            default: ;
         endcase
      end

      // frame load
      if (ld) begin
         cnt_in = cnt_n; crc_in = crc_n; first_in = first_n; last_in = last_n;
         if (req_last_byte) begin
            seq_in = req_frame_seq; stamp_in = req_stamp_ms;
            w_in = req_frame_width; h_in = req_frame_height;
            ldev_in = dev_ff; lver_in = ver_ff; lpay_in = pay_c; llen_in = cnt_n;
            lcrc_in = ~crc_n;
            big_in = cnt_n > CW'(jfcp_pkg::FRAME_BYTES);
            bad_in = (cnt_n < CW'(4)) || (first_n != {jfcp_pkg::MRK_FF, jfcp_pkg::MRK_SOI})
                     || (last_n != {jfcp_pkg::MRK_FF, jfcp_pkg::MRK_EOI});
            state_in = S_DIV;
            cnt_in = '0; crc_in = '1; first_in = '0; last_in = '0;
         end
      end

      // frame check once the chunk count is known
      if (state_ff == S_DIV && div_done) begin
         state_in = S_IDLE;
         if (big_ff || (dquot > jfcp_pkg::NUM_W'(16'hFFFF))) begin
            v_in = 1'b1; st_in = jfcp_pkg::ST_TOO_BIG;
         end else if (bad_ff) begin
            v_in = 1'b1; st_in = jfcp_pkg::ST_BAD;
         end else begin
            emit_in = 1'b1; ctot_in = dquot[15:0]; cnum_in = '0; pos_in = '0;
            coff_in = '0; rptr_in = '0;
         end
      end

      // packet byte
      if (adv) begin
         v_in = 1'b1; eop_in = eop; eof_in = eof;
         if (pos_ff < SW'(jfcp_pkg::HDR_LEN)) begin
            byte_in = hdr[8*hsel +: 8];
         end else begin
            usem_in = 1'b1;
            rptr_in = rptr_ff + AW'(1);
         end
         if (eop) begin
            pos_in  = '0;
            cnum_in = cnum_ff + 16'd1;
            coff_in = coff_ff + CW'(lpay_ff);
            if (eof) begin
               emit_in = 1'b0; cnum_in = '0;
            end
         end else begin
            pos_in = pos_ff + SW'(1);
         end
      end
   end

   // frame store port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= req_data_byte;
      end
      mem_q_ff <= mem[rptr_ff];
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; emit_ff <= 1'b0; v_ff <= 1'b0;
         dev_ff <= '0; ver_ff <= 2'd1; pay_cfg_ff <= PW'(1200);
         cnt_ff <= '0; crc_ff <= '1; first_ff <= '0; last_ff <= '0;
         ctot_ff <= '0; cnum_ff <= '0; pos_ff <= '0;
         seq_ff <= '0; stamp_ff <= '0; ldev_ff <= '0; lcrc_ff <= '0;
         w_ff <= '0; h_ff <= '0; lver_ff <= '0; lpay_ff <= '0; llen_ff <= '0;
      end else begin
         state_ff <= state_in; emit_ff <= emit_in; v_ff <= v_in;
         dev_ff <= dev_in; ver_ff <= ver_in; pay_cfg_ff <= pay_cfg_in;
         cnt_ff <= cnt_in; crc_ff <= crc_in; first_ff <= first_in; last_ff <= last_in;
         ctot_ff <= ctot_in; cnum_ff <= cnum_in; pos_ff <= pos_in;
         seq_ff <= seq_in; stamp_ff <= stamp_in; ldev_ff <= ldev_in; lcrc_ff <= lcrc_in;
         w_ff <= w_in; h_ff <= h_in; lver_ff <= lver_in; lpay_ff <= lpay_in;
         llen_ff <= llen_in;
      end
      big_ff <= big_in; bad_ff <= bad_in; coff_ff <= coff_in; rptr_ff <= rptr_in;
      usem_ff <= usem_in; eop_ff <= eop_in; eof_ff <= eof_in; byte_ff <= byte_in;
      st_ff <= st_in;
   end

   assign busy              = (state_ff == S_DIV);
   assign rsp_valid         = v_ff;
   assign rsp_out_byte      = usem_ff ? mem_q_ff : byte_ff;
   assign rsp_end_of_packet = eop_ff;
   assign rsp_end_of_frame  = eof_ff;
   assign rsp_status        = st_ff;

`ifndef SYNTHESIS
   // no emission while the chunk count is being worked out
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> !emit_ff) else $error("emitting during division");
   // drop results carry no packet flags
   a_drop_flags: assert property (@(posedge clock) disable iff (reset)
      (v_ff && st_ff != jfcp_pkg::ST_PACKET) |-> (!eop_ff && !eof_ff))
      else $error("drop word with packet flags");
   // frame end only on a packet end
   a_eof_eop: assert property (@(posedge clock) disable iff (reset)
      eof_ff |-> (eop_ff && v_ff)) else $error("frame end without packet end");
   // emission stops after the last word of a frame
   a_eof_stop: assert property (@(posedge clock) disable iff (reset)
      (adv && eof) |=> !emit_ff) else $error("emission continues past frame end");
`endif

endmodule

`default_nettype wire
